// ===== sv/bmp_4bpp_palette_decoder_macros.svh =====
// ---------------------------------------------------------------------------
// bmp_4bpp_palette_decoder_macros.svh
// Assertion shorthands shared by the job queue and lookup modules.
// ---------------------------------------------------------------------------
`ifndef BMP_4BPP_PALETTE_DECODER_MACROS_SVH
`define BMP_4BPP_PALETTE_DECODER_MACROS_SVH

// Clocked assertion, disabled while reset is held
`define BPD_ASSERT(name, prop, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// Implication form: when cond holds, check must hold in the same cycle
`define BPD_ASSERT_IMP(name, cond, check, msg) \
    `BPD_ASSERT(name, (cond) |-> (check), msg)

`endif

// ===== sv/bpd_pkg.sv =====
// ---------------------------------------------------------------------------
// bpd_pkg
// Shared types and constants of the 4-bit indexed bitmap decoder.
// ---------------------------------------------------------------------------
package bpd_pkg;

    // File format constants
    localparam logic [15:0] BMP_MAGIC    = 16'd19778;
    localparam logic [5:0]  HEADER_LAST  = 6'd53;
    localparam int          INDEX_BITS   = 4;
    localparam int          PAL_DEPTH    = 16;
    localparam logic [31:0] MAX_COLORS   = 32'd16;
    localparam int          QUEUE_DEPTH  = 4;

    // Result kinds
    localparam logic [1:0] KIND_PIXEL       = 2'd0;
    localparam logic [1:0] KIND_BAD_MAGIC   = 2'd1;
    localparam logic [1:0] KIND_BAD_PLANES  = 2'd2;
    localparam logic [1:0] KIND_UNSUPPORTED = 2'd3;

    // Job opcodes between front and back
    localparam logic [1:0] JOB_WR  = 2'd0;   // palette entry write
    localparam logic [1:0] JOB_PIX = 2'd1;   // one or two pixels
    localparam logic [1:0] JOB_ERR = 2'd2;   // error result

    typedef struct packed {
        logic [7:0] data_byte;
        logic       start_of_file;
    } t_item;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [11:0] pixel_row;
        logic [11:0] pixel_column;
        logic        last_pixel;
    } t_result;

    typedef struct packed {
        logic                  vld;
        logic [INDEX_BITS-1:0] idx;
        logic [11:0]           row;
        logic [11:0]           col;
        logic                  last;
    } t_pix;

    typedef struct packed {
        logic [1:0]  op;
        logic [1:0]  kind;
        logic [3:0]  addr;
        logic [23:0] rgb;
        t_pix        pix0;
        t_pix        pix1;
    } t_job;

endpackage

// ===== sv/bpd_front.sv =====
// ---------------------------------------------------------------------------
// bpd_front
// Byte parser: header checks, palette loading and pixel position tracking.
// Emits at most one job per accepted item.
// ---------------------------------------------------------------------------
module bpd_front #(
    parameter int MAX_WIDTH  = 4096,
    parameter int MAX_HEIGHT = 4096
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_accept,
    input  bpd_pkg::t_item i_item,
    output logic          o_job_vld,
    output bpd_pkg::t_job o_job
);
    import bpd_pkg::*;

    localparam int WB = $clog2(MAX_WIDTH + 1);
    localparam int HB = $clog2(MAX_HEIGHT + 1);

    localparam logic [2:0] PH_IDLE    = 3'd0;
    localparam logic [2:0] PH_HEADER  = 3'd1;
    localparam logic [2:0] PH_PALETTE = 3'd2;
    localparam logic [2:0] PH_PIXELS  = 3'd3;
    localparam logic [2:0] PH_DONE    = 3'd4;

    logic [2:0]    r_phase,    n_phase;
    logic [5:0]    r_hcnt,     n_hcnt;
    logic [7:0]    r_magic_lo, n_magic_lo;
    logic [7:0]    r_plane_lo, n_plane_lo;
    logic [31:0]   r_width,    n_width;
    logic [31:0]   r_height,   n_height;
    logic [31:0]   r_colors,   n_colors;
    logic [4:0]    r_pal_cnt,  n_pal_cnt;
    logic [1:0]    r_ent_byte, n_ent_byte;
    logic [7:0]    r_blue,     n_blue;
    logic [7:0]    r_green,    n_green;
    logic [4:0]    r_entries,  n_entries;
    logic [WB-1:0] r_col,      n_col;
    logic [HB-1:0] r_rowd,     n_rowd;
    logic [2:0]    r_pad,      n_pad;

    logic [2:0]    eff_phase;
    logic [5:0]    k;
    logic [7:0]    b;
    logic [1:0]    lane;
    logic [4:0]    ent_inc;
    logic          active;
    logic [3:0]    nib;
    logic [WB-1:0] col_nxt;
    t_pix          pix [2];
    t_job          job;
    logic          job_vld;

    // Parser next state and job build
    always_comb begin
        n_phase    = r_phase;
        n_hcnt     = r_hcnt;
        n_magic_lo = r_magic_lo;
        n_plane_lo = r_plane_lo;
        n_width    = r_width;
        n_height   = r_height;
        n_colors   = r_colors;
        n_pal_cnt  = r_pal_cnt;
        n_ent_byte = r_ent_byte;
        n_blue     = r_blue;
        n_green    = r_green;
        n_entries  = r_entries;
        n_col      = r_col;
        n_rowd     = r_rowd;
        n_pad      = r_pad;
        job        = '0;
        job_vld    = 1'b0;
        b          = i_item.data_byte;
        eff_phase  = i_item.start_of_file ? PH_HEADER : r_phase;
        k          = i_item.start_of_file ? 6'd0 : r_hcnt;
        lane       = 2'd0;
        ent_inc    = r_entries + 5'd1;
        active     = 1'b0;
        nib        = '0;
        col_nxt    = '0;
        pix[0]     = '0;
        pix[1]     = '0;

        if (i_accept) begin
            if (i_item.start_of_file) begin
                n_phase = PH_HEADER;
            end
            case (eff_phase)
                PH_HEADER: begin
                    n_hcnt = k + 6'd1;
                    if (k == 6'd0) begin
                        n_magic_lo = b;
                    end
                    if (k == 6'd1 && {b, r_magic_lo} != BMP_MAGIC) begin
                        n_phase  = PH_DONE;
                        job_vld  = 1'b1;
                        job.op   = JOB_ERR;
                        job.kind = KIND_BAD_MAGIC;
                    end
                    if (k inside {[6'd18:6'd21]}) begin
                        lane = 2'(k - 6'd18);
                        n_width[{lane, 3'b000} +: 8] = b;
                    end
                    if (k inside {[6'd22:6'd25]}) begin
                        lane = 2'(k - 6'd22);
                        n_height[{lane, 3'b000} +: 8] = b;
                    end
                    if (k == 6'd26) begin
                        n_plane_lo = b;
                    end
                    if (k == 6'd27 && {b, r_plane_lo} != 16'd1) begin
                        n_phase  = PH_DONE;
                        job_vld  = 1'b1;
                        job.op   = JOB_ERR;
                        job.kind = KIND_BAD_PLANES;
                    end
                    if (k inside {[6'd46:6'd49]}) begin
                        lane = 2'(k - 6'd46);
                        n_colors[{lane, 3'b000} +: 8] = b;
                    end
                    // End of header: size and palette checks
                    if (k == HEADER_LAST) begin
                        if (r_colors > MAX_COLORS || r_width > 32'(MAX_WIDTH) ||
                            r_height > 32'(MAX_HEIGHT)) begin
                            n_phase  = PH_DONE;
                            job_vld  = 1'b1;
                            job.op   = JOB_ERR;
                            job.kind = KIND_UNSUPPORTED;
                        end else begin
                            n_phase    = PH_PALETTE;
                            n_pal_cnt  = (r_colors == 32'd0) ? 5'd16 : r_colors[4:0];
                            n_ent_byte = 2'd0;
                            n_entries  = 5'd0;
                        end
                    end
                end
                PH_PALETTE: begin
                    n_ent_byte = r_ent_byte + 2'd1;
                    case (r_ent_byte)
                        2'd0: n_blue  = b;
                        2'd1: n_green = b;
                        2'd2: begin
                            job_vld  = 1'b1;
                            job.op   = JOB_WR;
                            job.addr = r_entries[3:0];
                            job.rgb  = {b, r_green, r_blue};
                        end
                        default: begin
                            n_entries = ent_inc;
                            if (ent_inc >= r_pal_cnt) begin
                                n_col  = '0;
                                n_rowd = HB'(r_height - 32'd1);
                                n_pad  = 3'd0;
                                n_phase = (r_width == 32'd0 || r_height == 32'd0) ?
                                          PH_DONE : PH_PIXELS;
                            end
                        end
                    endcase
                end
                PH_PIXELS: begin
                    // Two nibbles, high first; padding nibbles are dropped
                    active = 1'b1;
                    for (int n = 0; n < 2; n++) begin
                        nib = (n == 0) ? b[7:4] : b[3:0];
                        if (active) begin
                            if (n_pad != 3'd0) begin
                                n_pad = n_pad - 3'd1;
                            end else begin
                                pix[n].vld = 1'b1;
                                pix[n].idx = nib;
                                pix[n].row = 12'(n_rowd);
                                pix[n].col = 12'(n_col);
                                col_nxt    = n_col + WB'(1);
                                if (32'(col_nxt) == r_width) begin
                                    n_col = '0;
                                    n_pad = 3'd0 - r_width[2:0];
                                    if (n_rowd == '0) begin
                                        pix[n].last = 1'b1;
                                        active      = 1'b0;
                                        n_phase     = PH_DONE;
                                    end else begin
                                        n_rowd = n_rowd - HB'(1);
                                    end
                                end else begin
                                    n_col = col_nxt;
                                end
                            end
                        end
                    end
                    job.op   = JOB_PIX;
                    job.pix0 = pix[0];
                    job.pix1 = pix[1];
                    job_vld  = pix[0].vld | pix[1].vld;
                end
                default: ;
            endcase
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_IDLE;
            r_hcnt     <= '0;
            r_ent_byte <= '0;
            r_entries  <= '0;
            r_pal_cnt  <= '0;
            r_col      <= '0;
            r_rowd     <= '0;
            r_pad      <= '0;
        end else begin
            r_phase    <= n_phase;
            r_hcnt     <= n_hcnt;
            r_ent_byte <= n_ent_byte;
            r_entries  <= n_entries;
            r_pal_cnt  <= n_pal_cnt;
            r_col      <= n_col;
            r_rowd     <= n_rowd;
            r_pad      <= n_pad;
        end
    end

    // Header fields and partial color
    always_ff @(posedge i_clk) begin
        r_magic_lo <= n_magic_lo;
        r_plane_lo <= n_plane_lo;
        r_width    <= n_width;
        r_height   <= n_height;
        r_colors   <= n_colors;
        r_blue     <= n_blue;
        r_green    <= n_green;
    end

    assign o_job_vld = job_vld;
    assign o_job     = job;

endmodule

// ===== sv/bpd_queue.sv =====
// ---------------------------------------------------------------------------
// bpd_queue
// Short job queue between the parser and the palette lookup stage.
// ---------------------------------------------------------------------------
`include "bmp_4bpp_palette_decoder_macros.svh"

module bpd_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  bpd_pkg::t_job i_data,
    input  logic          i_pop,
    output bpd_pkg::t_job o_data,
    output logic          o_full,
    output logic          o_empty
);
    import bpd_pkg::*;

    localparam int PB = $clog2(QUEUE_DEPTH);

    t_job          r_mem [QUEUE_DEPTH];
    logic [PB-1:0] r_wr_ptr;
    logic [PB-1:0] r_rd_ptr;
    logic [PB:0]   r_count;
    logic          do_push;
    logic          do_pop;

    assign o_full  = (r_count == (PB+1)'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd_ptr];

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + PB'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + PB'(1);
            end
            r_count <= r_count + (PB+1)'(do_push) - (PB+1)'(do_pop);
        end
    end

    // Storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    `BPD_ASSERT(a_count_range, r_count <= (PB+1)'(QUEUE_DEPTH), "queue count over depth")
    `BPD_ASSERT(a_ptr_track, r_wr_ptr == PB'(r_rd_ptr + r_count[PB-1:0]), "pointers out of step")
    `BPD_ASSERT_IMP(a_no_overflow, i_push, !o_full, "job pushed into full queue")

endmodule

// ===== sv/bpd_back.sv =====
// ---------------------------------------------------------------------------
// bpd_back
// Executes jobs: palette writes, palette lookups and the result register.
// One result per cycle while the result register is empty or being popped.
// ---------------------------------------------------------------------------
`include "bmp_4bpp_palette_decoder_macros.svh"

module bpd_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_q_empty,
    input  bpd_pkg::t_job    i_q_data,
    output logic             o_q_pop,
    input  logic             i_pop,
    output logic             o_empty,
    output bpd_pkg::t_result o_result
);
    import bpd_pkg::*;

    typedef struct packed {
        logic [1:0]  kind;
        logic [11:0] row;
        logic [11:0] col;
        logic        last;
    } t_meta;

    logic [23:0] r_pal [PAL_DEPTH];
    logic [23:0] r_rd_data;
    t_meta       r_meta;
    logic        r_s2_vld;
    logic        r_sub, n_sub;

    logic                  adv;
    logic                  mem_we;
    logic                  iss_vld;
    logic                  iss_pix;
    logic [INDEX_BITS-1:0] iss_idx;
    t_meta                 iss_meta;

    assign adv = !r_s2_vld || i_pop;

    // Job sequencing: one pixel issued per cycle while the result stage advances
    always_comb begin
        o_q_pop  = 1'b0;
        n_sub    = r_sub;
        mem_we   = 1'b0;
        iss_vld  = 1'b0;
        iss_pix  = 1'b0;
        iss_idx  = '0;
        iss_meta = '0;
        if (!i_q_empty && adv) begin
            case (i_q_data.op)
                JOB_WR: begin
                    mem_we  = 1'b1;
                    o_q_pop = 1'b1;
                end
                JOB_ERR: begin
                    iss_vld       = 1'b1;
                    iss_meta.kind = i_q_data.kind;
                    o_q_pop       = 1'b1;
                end
                JOB_PIX: begin
                    iss_vld       = 1'b1;
                    iss_pix       = 1'b1;
                    iss_meta.kind = KIND_PIXEL;
                    if (!r_sub && i_q_data.pix0.vld) begin
                        iss_idx       = i_q_data.pix0.idx;
                        iss_meta.row  = i_q_data.pix0.row;
                        iss_meta.col  = i_q_data.pix0.col;
                        iss_meta.last = i_q_data.pix0.last;
                        if (i_q_data.pix1.vld) begin
                            n_sub = 1'b1;
                        end else begin
                            o_q_pop = 1'b1;
                        end
                    end else begin
                        iss_idx       = i_q_data.pix1.idx;
                        iss_meta.row  = i_q_data.pix1.row;
                        iss_meta.col  = i_q_data.pix1.col;
                        iss_meta.last = i_q_data.pix1.last;
                        n_sub         = 1'b0;
                        o_q_pop       = 1'b1;
                    end
                end
                default: o_q_pop = 1'b1;
            endcase
        end
    end

    // Control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sub    <= 1'b0;
            r_s2_vld <= 1'b0;
        end else begin
            r_sub <= n_sub;
            if (adv) begin
                r_s2_vld <= iss_vld;
            end
        end
    end

    // Result metadata
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_meta <= iss_meta;
        end
    end

    // Palette memory, registered read
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_pal[i_q_data.addr] <= i_q_data.rgb;
        end
        if (adv && iss_pix) begin
            r_rd_data <= r_pal[iss_idx];
        end
    end

    // Result port
    always_comb begin
        o_empty               = !r_s2_vld;
        o_result.kind         = r_meta.kind;
        o_result.red          = (r_meta.kind == KIND_PIXEL) ? r_rd_data[23:16] : 8'd0;
        o_result.green        = (r_meta.kind == KIND_PIXEL) ? r_rd_data[15:8]  : 8'd0;
        o_result.blue         = (r_meta.kind == KIND_PIXEL) ? r_rd_data[7:0]   : 8'd0;
        o_result.pixel_row    = r_meta.row;
        o_result.pixel_column = r_meta.col;
        o_result.last_pixel   = r_meta.last;
    end

    `BPD_ASSERT_IMP(a_sub_on_pair, r_sub,
        !i_q_empty && i_q_data.op == JOB_PIX && i_q_data.pix1.vld,
        "second pixel pending without a pixel pair at queue head")
    `BPD_ASSERT_IMP(a_pix_job_nonempty, !i_q_empty && i_q_data.op == JOB_PIX,
        i_q_data.pix0.vld || i_q_data.pix1.vld, "pixel job without pixels")
    `BPD_ASSERT_IMP(a_err_fields_zero, r_s2_vld && r_meta.kind != KIND_PIXEL,
        r_meta.row == 12'd0 && r_meta.col == 12'd0 && !r_meta.last,
        "error result carries position")

endmodule

// ===== sv/bmp_4bpp_palette_decoder.sv =====
// ---------------------------------------------------------------------------
// bmp_4bpp_palette_decoder
// Streaming decoder for 4-bit indexed bitmap files: header checks, palette
// load and one RGB pixel item per index.
//
//   Channel   Direction  Handshake             Payload
//   input     in         push / full           i_item   (data_byte, start_of_file)
//   result    out        empty / pop           o_result (kind, rgb, row, col, last)
//
// The parser takes one input item per cycle while the job queue has room.
// The palette lookup stage delivers one result per cycle while results are
// popped; a pixel byte (two pixels) yields two results.
// A byte's job passes through the job queue and then the result register.
// Synchronous active-low reset clears all control state; no clearing pass.
// A stalled result register backs up the queue, then full rises.
// ---------------------------------------------------------------------------
module bmp_4bpp_palette_decoder #(
    parameter int MAX_WIDTH  = 4096,
    parameter int MAX_HEIGHT = 4096
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             push,
    input  bpd_pkg::t_item   i_item,
    output logic             full,
    output logic             empty,
    input  logic             pop,
    output bpd_pkg::t_result o_result
);
    import bpd_pkg::*;

    logic accept;
    logic job_vld;
    t_job job;
    t_job q_data;
    logic q_empty;
    logic q_pop;

    assign accept = push && !full;

    // Parser
    bpd_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_accept  (accept),
        .i_item    (i_item),
        .o_job_vld (job_vld),
        .o_job     (job)
    );

    // Job queue
    bpd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (job_vld),
        .i_data  (job),
        .i_pop   (q_pop),
        .o_data  (q_data),
        .o_full  (full),
        .o_empty (q_empty)
    );

    // Lookup and result stage
    bpd_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_empty (q_empty),
        .i_q_data  (q_data),
        .o_q_pop   (q_pop),
        .i_pop     (pop),
        .o_empty   (empty),
        .o_result  (o_result)
    );

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_top
// Self-checking bench for the 4-bit indexed bitmap decoder. Whole files are
// built byte by byte: a table of hand-picked files (header errors, size and
// palette extremes, padding, restarts) and then random files with random
// content. A decoder model in the bench predicts every result item, and
// each popped item is compared field by field in arrival order.
// ---------------------------------------------------------------------------
module tb_top;
    import bpd_pkg::*;

    localparam int unsigned SIZE_LIMIT   = 4096;
    localparam int          RAND_ITEMS   = 1150;
    localparam int          HOLD_CYCLES  = 300;
    localparam int          DRAIN_CYCLES = 16;
    localparam int          MAX_REPORTS  = 40;

    // One bitmap file to build; err is the typed-in error kind, if any
    typedef struct {
        logic [15:0] magic;
        logic [15:0] planes;
        logic [31:0] width;
        logic [31:0] height;
        logic [31:0] colors;
        int          cut;
        logic [1:0]  err;
    } file_spec_t;

    typedef enum logic [2:0] {
        ST_IDLE, ST_HEADER, ST_PALETTE, ST_PIXELS, ST_DONE
    } parse_st_t;

    logic    i_clk   = 1'b0;
    logic    i_rst_n = 1'b0;
    logic    push    = 1'b0;
    t_item   i_item  = '0;
    logic    pop     = 1'b0;
    logic    full;
    logic    empty;
    t_result o_result;

    // Decoder model state
    parse_st_t   st;
    int unsigned hdr_cnt;
    logic [15:0] magic_w;
    logic [7:0]  plane_lo;
    logic [31:0] img_w, img_h, colors_w, pal_cnt;
    logic [31:0] cur_row, cur_col, pad_left, ent_loaded;
    logic [1:0]  ent_byte;
    logic [7:0]  part_b, part_g;
    logic [23:0] pal [16];
    logic [15:0] pal_written;
    t_result     step_res [2];
    int          step_n;

    t_result     decoded_q [$];
    logic [7:0]  file_q [$];

    int  send_idle_pct  = 0;
    int  recv_stall_pct = 0;
    int  used_bytes     = 0;
    int  files_sent     = 0;
    int  files_cut      = 0;
    int  fail_cnt       = 0;
    int  res_pix        = 0;
    int  res_err        = 0;
    logic hold_toggle   = 1'b0;
    logic hold_seen     = 1'b0;
    int  hold_left      = 0;

    file_spec_t dir_tab [24] = '{
        '{BMP_MAGIC, 16'd1,      32'd8,    32'd2,    32'd0,  0, KIND_PIXEL},
        '{16'h424D,  16'd1,      32'd8,    32'd2,    32'd0,  0, KIND_BAD_MAGIC},
        '{16'h4D43,  16'd1,      32'd8,    32'd2,    32'd0,  0, KIND_BAD_MAGIC},
        '{16'hFFFF,  16'd1,      32'd8,    32'd2,    32'd0,  0, KIND_BAD_MAGIC},
        '{16'h0000,  16'd1,      32'd8,    32'd2,    32'd0,  0, KIND_BAD_MAGIC},
        '{BMP_MAGIC, 16'd0,      32'd8,    32'd2,    32'd0,  0, KIND_BAD_PLANES},
        '{BMP_MAGIC, 16'h0101,   32'd8,    32'd2,    32'd0,  0, KIND_BAD_PLANES},
        '{BMP_MAGIC, 16'hFFFF,   32'd8,    32'd2,    32'd0,  0, KIND_BAD_PLANES},
        '{BMP_MAGIC, 16'd1,      32'd8,    32'd2,    32'd17, 0, KIND_UNSUPPORTED},
        '{BMP_MAGIC, 16'd1,      32'd8,    32'd2,    32'hFFFF_FFFF, 0, KIND_UNSUPPORTED},
        '{BMP_MAGIC, 16'd1,      32'd4097, 32'd2,    32'd4,  0, KIND_UNSUPPORTED},
        '{BMP_MAGIC, 16'd1,      32'hFFFF_FFFF, 32'd2, 32'd4, 0, KIND_UNSUPPORTED},
        '{BMP_MAGIC, 16'd1,      32'd8,    32'd4097, 32'd4,  0, KIND_UNSUPPORTED},
        '{BMP_MAGIC, 16'd1,      32'd8,    32'h8000_0000, 32'd4, 0, KIND_UNSUPPORTED},
        '{BMP_MAGIC, 16'd1,      32'd0,    32'd3,    32'd2,  0, KIND_PIXEL},
        '{BMP_MAGIC, 16'd1,      32'd3,    32'd0,    32'd0,  0, KIND_PIXEL},
        '{BMP_MAGIC, 16'd1,      32'd1,    32'd1,    32'd1,  0, KIND_PIXEL},
        '{BMP_MAGIC, 16'd1,      32'd9,    32'd3,    32'd16, 0, KIND_PIXEL},
        '{BMP_MAGIC, 16'd1,      32'd7,    32'd5,    32'd3,  0, KIND_PIXEL},
        '{BMP_MAGIC, 16'd1,      32'd4096, 32'd1,    32'd2,  0, KIND_PIXEL},
        '{BMP_MAGIC, 16'd1,      32'd1,    32'd4096, 32'd4,  110, KIND_PIXEL},
        '{BMP_MAGIC, 16'd1,      32'd5,    32'd4,    32'd5,  30, KIND_PIXEL},
        '{BMP_MAGIC, 16'd1,      32'd5,    32'd4,    32'd5,  60, KIND_PIXEL},
        '{BMP_MAGIC, 16'd1,      32'd4096, 32'd4096, 32'd16, 140, KIND_PIXEL}
    };

    bmp_4bpp_palette_decoder #(
        .MAX_WIDTH  (SIZE_LIMIT),
        .MAX_HEIGHT (SIZE_LIMIT)
    ) u_top (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .push     (push),
        .i_item   (i_item),
        .full     (full),
        .empty    (empty),
        .pop      (pop),
        .o_result (o_result)
    );

    // 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Decoder model
    // ------------------------------------------------------------------
    function automatic void emit(logic [1:0] kind, logic [23:0] rgb, logic [31:0] row,
                                 logic [31:0] col, logic last);
        t_result r;
        r.kind         = kind;
        r.red          = rgb[23:16];
        r.green        = rgb[15:8];
        r.blue         = rgb[7:0];
        r.pixel_row    = row[11:0];
        r.pixel_column = col[11:0];
        r.last_pixel   = last;
        step_res[step_n] = r;
        step_n++;
    endfunction

    // One palette index from a pixel byte; padding nibbles are dropped
    function automatic void lookup_nibble(logic [3:0] idx);
        logic [31:0] row;
        logic [31:0] col;
        logic [31:0] row_bits;
        logic        last;
        if (st != ST_PIXELS) return;
        if (pad_left != 0) begin
            pad_left -= INDEX_BITS;
            return;
        end
        row  = img_h - 1 - cur_row;
        col  = cur_col;
        last = 1'b0;
        cur_col++;
        if (cur_col >= img_w) begin
            cur_col  = 0;
            row_bits = (img_w * INDEX_BITS) % 32;
            pad_left = (row_bits != 0) ? 32 - row_bits : 0;
            cur_row++;
            if (cur_row >= img_h) begin
                last = 1'b1;
                st   = ST_DONE;
            end
        end
        emit(KIND_PIXEL, pal[idx], row, col, last);
    endfunction

    // Advance the model by one accepted byte; results land in step_res
    function automatic void decode_byte(t_item it, output bit used);
        logic [7:0]  b;
        int unsigned k;
        b      = it.data_byte;
        step_n = 0;
        if (it.start_of_file) begin
            st = ST_HEADER;
            hdr_cnt = 0;
            img_w = 0; img_h = 0; colors_w = 0; pal_cnt = 0;
            ent_byte = 0; part_b = 0; part_g = 0; ent_loaded = 0;
            cur_row = 0; cur_col = 0; pad_left = 0;
            magic_w = 0; plane_lo = 0;
        end
        used = (st == ST_HEADER) || (st == ST_PALETTE) || (st == ST_PIXELS);
        case (st)
            ST_HEADER: begin
                k = hdr_cnt;
                hdr_cnt++;
                if (k < 2) magic_w[8*k +: 8] = b;
                else if (k >= 18 && k < 22) img_w[8*(k-18) +: 8] = b;
                else if (k >= 22 && k < 26) img_h[8*(k-22) +: 8] = b;
                else if (k == 26) plane_lo = b;
                else if (k >= 46 && k < 50) colors_w[8*(k-46) +: 8] = b;

                if (k == 1 && magic_w != BMP_MAGIC) begin
                    st = ST_DONE;
                    emit(KIND_BAD_MAGIC, '0, '0, '0, 1'b0);
                end else if (k == 27 && {b, plane_lo} != 16'd1) begin
                    st = ST_DONE;
                    emit(KIND_BAD_PLANES, '0, '0, '0, 1'b0);
                end else if (k == HEADER_LAST) begin
                    pal_cnt = (colors_w != 0) ? colors_w : 32'd16;
                    if (pal_cnt > MAX_COLORS || img_w > SIZE_LIMIT || img_h > SIZE_LIMIT)
                    begin
                        st = ST_DONE;
                        emit(KIND_UNSUPPORTED, '0, '0, '0, 1'b0);
                    end else begin
                        st = ST_PALETTE;
                    end
                end
            end
            ST_PALETTE: begin
                // entries arrive as blue, green, red, reserved
                if (ent_byte == 0) part_b = b;
                else if (ent_byte == 1) part_g = b;
                else if (ent_byte == 2) begin
                    pal[ent_loaded[3:0]]         = {b, part_g, part_b};
                    pal_written[ent_loaded[3:0]] = 1'b1;
                end
                if (ent_byte == 3) begin
                    ent_byte = 0;
                    ent_loaded++;
                    if (ent_loaded >= pal_cnt) begin
                        cur_row  = 0;
                        cur_col  = 0;
                        pad_left = 0;
                        st = (img_w == 0 || img_h == 0) ? ST_DONE : ST_PIXELS;
                    end
                end else begin
                    ent_byte++;
                end
            end
            ST_PIXELS: begin
                lookup_nibble(b[7:4]);
                lookup_nibble(b[3:0]);
            end
            default: ;
        endcase
    endfunction

    // ------------------------------------------------------------------
    // File construction
    // ------------------------------------------------------------------
    // Index for a pixel: never one whose palette entry was never loaded
    function automatic logic [3:0] pick_index(int unsigned ncol);
        logic [3:0] idx;
        idx = 4'($urandom_range(15));
        if (idx >= ncol && !pal_written[idx]) idx = 4'($urandom_range(ncol - 1));
        return idx;
    endfunction

    function automatic void build_file(file_spec_t f, output int err_at);
        logic [7:0]  hdr [54];
        int          stop;
        int          row_bytes;
        int          max_len;
        int unsigned ncol;
        logic [3:0]  hi, lo;
        file_q.delete();
        for (int k = 0; k < 54; k++) hdr[k] = 8'($urandom_range(255));
        hdr[0]  = f.magic[7:0];
        hdr[1]  = f.magic[15:8];
        hdr[26] = f.planes[7:0];
        hdr[27] = f.planes[15:8];
        for (int j = 0; j < 4; j++) begin
            hdr[18+j] = f.width[8*j +: 8];
            hdr[22+j] = f.height[8*j +: 8];
            hdr[46+j] = f.colors[8*j +: 8];
        end
        stop = 54;
        if (f.magic != BMP_MAGIC) stop = 2;
        else if (f.planes != 16'd1) stop = 28;
        for (int k = 0; k < stop; k++) file_q.push_back(hdr[k]);

        case (f.err)
            KIND_BAD_MAGIC:   err_at = 1;
            KIND_BAD_PLANES:  err_at = 27;
            KIND_UNSUPPORTED: err_at = 53;
            default:          err_at = -1;
        endcase

        max_len = (f.cut > 0) ? f.cut : 32'h7FFF_FFFF;
        ncol    = (f.colors == 0) ? 16 : f.colors;
        if (stop == 54 && ncol <= 16 && f.width <= SIZE_LIMIT && f.height <= SIZE_LIMIT)
        begin
            repeat (4 * ncol) file_q.push_back(8'($urandom_range(255)));
            row_bytes = ((f.width * INDEX_BITS + 31) / 32) * 4;
            if (f.width != 0) begin
                for (int r = 0; r < f.height && file_q.size() < max_len; r++) begin
                    for (int j = 0; j < row_bytes; j++) begin
                        // columns past the width are padding: any value
                        hi = (2*j   < f.width) ? pick_index(ncol) : 4'($urandom_range(15));
                        lo = (2*j+1 < f.width) ? pick_index(ncol) : 4'($urandom_range(15));
                        file_q.push_back({hi, lo});
                    end
                end
            end
        end
        // trailing bytes after the end of the image are ignored
        if (f.cut == 0) repeat ($urandom_range(2)) file_q.push_back(8'($urandom_range(255)));
        while (file_q.size() > max_len) void'(file_q.pop_back());
    endfunction

    function automatic file_spec_t rand_spec();
        file_spec_t f;
        int         r;
        f.magic  = BMP_MAGIC;
        f.planes = 16'd1;
        f.width  = ($urandom_range(19) == 0) ? 0 : $urandom_range(1, 12);
        f.height = ($urandom_range(19) == 0) ? 0 : $urandom_range(1, 5);
        f.colors = $urandom_range(16);
        f.cut    = ($urandom_range(99) < 8) ? $urandom_range(1, 150) : 0;
        f.err    = KIND_PIXEL;
        r = $urandom_range(99);
        if (r < 4) f.magic = BMP_MAGIC ^ 16'($urandom_range(1, 16'hFFFF));
        else if (r < 8) f.planes = 16'd1 ^ 16'($urandom_range(1, 16'hFFFF));
        else if (r < 14) begin
            case ($urandom_range(3))
                0: f.colors = $urandom_range(17, 300);
                1: f.colors = $urandom | 32'h8000_0000;
                2: f.width  = SIZE_LIMIT + $urandom_range(1, 5000);
                default: f.height = $urandom | 32'h0001_0000;
            endcase
        end else if (r < 17) begin
            f.width = $urandom_range(13, 64);
        end
        return f;
    endfunction

    // ------------------------------------------------------------------
    // Byte sender
    // ------------------------------------------------------------------
    task automatic send_byte(input logic [7:0] b, input logic sof, input bit typed,
                             input t_result typed_res);
        t_item it;
        bit    used;
        it.data_byte     = b;
        it.start_of_file = sof;
        while ($urandom_range(99) < send_idle_pct) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push   <= 1'b1;
        i_item <= it;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        decode_byte(it, used);
        if (typed) decoded_q.push_back(typed_res);
        else for (int i = 0; i < step_n; i++) decoded_q.push_back(step_res[i]);
        if (used) used_bytes++;
    endtask

    task automatic send_file(input file_spec_t f, input bit typed);
        int      err_at;
        t_result tr;
        build_file(f, err_at);
        tr      = '0;
        tr.kind = f.err;
        files_sent++;
        if (f.cut != 0) files_cut++;
        foreach (file_q[i]) send_byte(file_q[i], i == 0, typed && i == err_at, tr);
    endtask

    // ------------------------------------------------------------------
    // Result receiver: random stalls, plus one long hold-off on request
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pop       <= 1'b0;
            hold_left <= 0;
            hold_seen <= hold_toggle;
        end else if (hold_seen != hold_toggle) begin
            hold_seen <= hold_toggle;
            hold_left <= HOLD_CYCLES;
            pop       <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            pop       <= 1'b0;
        end else begin
            pop <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    function automatic void check_field(string fname, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            fail_cnt++;
            if (fail_cnt <= MAX_REPORTS)
                $display("%0t: %s mismatch, expected %0h, actual %0h", $time, fname, want, got);
        end
    endfunction

    // Compare each popped item against the oldest prediction
    always @(posedge i_clk) begin : result_check
        t_result want;
        if (i_rst_n && pop && !empty) begin
            if (decoded_q.size() == 0) begin
                fail_cnt++;
                if (fail_cnt <= MAX_REPORTS)
                    $display("%0t: unexpected result item, expected none, actual %h",
                             $time, o_result);
            end else begin
                want = decoded_q.pop_front();
                check_field("kind",         want.kind,         o_result.kind);
                check_field("red",          want.red,          o_result.red);
                check_field("green",        want.green,        o_result.green);
                check_field("blue",         want.blue,         o_result.blue);
                check_field("pixel_row",    want.pixel_row,    o_result.pixel_row);
                check_field("pixel_column", want.pixel_column, o_result.pixel_column);
                check_field("last_pixel",   want.last_pixel,   o_result.last_pixel);
                if (want.kind == KIND_PIXEL) res_pix++;
                else res_err++;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial begin : stimulus
        file_spec_t f;
        int         rand_base;
        int         ph;
        bit         hold_done;
        st          = ST_IDLE;
        pal_written = '0;
        foreach (pal[i]) pal[i] = '0;
        hold_done   = 1'b0;

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // bytes with no start mark while idle are dropped
        send_byte(8'hA5, 1'b0, 1'b0, '0);
        send_byte(8'h5A, 1'b0, 1'b0, '0);

        foreach (dir_tab[i]) send_file(dir_tab[i], 1'b1);

        // random files across four idling phases
        rand_base = used_bytes;
        while (used_bytes - rand_base < RAND_ITEMS) begin
            ph = (used_bytes - rand_base) * 4 / RAND_ITEMS;
            case (ph)
                0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1:       begin send_idle_pct = 58; recv_stall_pct = 0;  end
                2:       begin send_idle_pct = 0;  recv_stall_pct = 58; end
                default: begin send_idle_pct = 30; recv_stall_pct = 30; end
            endcase
            // long receiver hold while the sender keeps pushing
            if (!hold_done) begin
                hold_toggle <= ~hold_toggle;
                hold_done = 1'b1;
            end
            f = rand_spec();
            send_file(f, 1'b0);
            if (f.cut == 0 && $urandom_range(9) == 0)
                repeat ($urandom_range(1, 3)) send_byte(8'($urandom_range(255)), 1'b0, 1'b0, '0);
        end
        push <= 1'b0;

        recv_stall_pct = 0;
        while (decoded_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("files: %0d sent, %0d cut short by a restart; bytes parsed: %0d",
                 files_sent, files_cut, used_bytes);
        $display("result items checked: %0d pixels, %0d header errors", res_pix, res_err);
        if (fail_cnt == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #2_000_000;
        $display("tb: failure");
        $finish;
    end

endmodule
